// File: hdl/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

// File: hdl/uds_pkg.sv
`default_nettype none
package uds_pkg;

  localparam int KEY_W        = 32;
  localparam int CAPACITY_DEF = 64;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic ins;
    logic drain;
    key_t key;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

endpackage
`default_nettype wire

// File: hdl/uds_cell.sv
`default_nettype none
module uds_cell (
  input  wire                clk,
  input  wire                rst_n,
  input  uds_pkg::cell_ctrl_t ctrl,
  input  wire                left_gt,
  input  uds_pkg::key_t      left_key,
  input  wire                left_valid,
  input  uds_pkg::key_t      right_key,
  input  wire                right_valid,
  output uds_pkg::key_t      key_o,
  output logic               valid_o,
  output logic               gt_o,
  output logic               eq_o
);
  import uds_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic valid_r;
  logic valid_nxt;

  assign gt_o    = valid_r && (key_r > ctrl.key);
  assign eq_o    = valid_r && (key_r == ctrl.key);
  assign key_o   = key_r;
  assign valid_o = valid_r;

  always_comb begin
    priority if (ctrl.drain) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end else if (ctrl.ins && !gt_o) begin
      if (left_gt) begin
        key_nxt   = ctrl.key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = left_key;
        valid_nxt = left_valid;
      end
    end else begin
      key_nxt   = key_r;
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/unique_descending_sorter_unit.sv
`default_nettype none
// Collects a set of signed 32-bit keys into a chain of CAPACITY cells kept in
// descending order, dropping repeats, and accepts one key per cycle while
// collecting. The transaction marked last is inserted like any other; the
// block then stops accepting input and drains the chain from cell 0, one
// result per cycle of the output handshake, so each occupied cell gives one
// result before input is taken again, the chain being empty afterwards.
// Distinct keys that arrive with all cells filled are dropped and
// out_overflow is set on every result of that run.
module unique_descending_sorter_unit #(
  parameter int CAPACITY = uds_pkg::CAPACITY_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  uds_pkg::key_t in_key,
  input  wire           in_last,
  output logic          out_valid,
  input  wire           out_ready,
  output uds_pkg::key_t out_key,
  output logic          out_last,
  output logic          out_overflow
);
  import uds_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic       overflow_seen_r;
  logic       overflow_seen_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  key_t       out_key_r;
  logic       out_last_r;
  logic       out_overflow_r;

  cell_ctrl_t        ctrl;
  key_t              key_vec [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] eq_vec;

  logic accept;
  logic dup;
  logic full;
  logic load;
  logic run_end;

  assign in_ready = (state_r == ST_COLLECT);
  assign accept   = in_valid && in_ready;
  assign dup      = |eq_vec;
  assign full     = valid_vec[CAPACITY-1];
  assign load     = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign run_end  = load && !valid_vec[1];

  assign ctrl.ins   = accept && !dup && !full;
  assign ctrl.drain = load;
  assign ctrl.key   = in_key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic l_gt;
    key_t l_key;
    logic l_valid;
    key_t r_key;
    logic r_valid;
    if (i == 0) begin : g_first
      assign l_gt    = 1'b1;
      assign l_key   = in_key;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_gt    = gt_vec[i-1];
      assign l_key   = key_vec[i-1];
      assign l_valid = valid_vec[i-1];
    end
    if (i == CAPACITY-1) begin : g_tail
      assign r_key   = key_vec[i];
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_key   = key_vec[i+1];
      assign r_valid = valid_vec[i+1];
    end
    uds_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_gt    (l_gt),
      .left_key   (l_key),
      .left_valid (l_valid),
      .right_key  (r_key),
      .right_valid(r_valid),
      .key_o      (key_vec[i]),
      .valid_o    (valid_vec[i]),
      .gt_o       (gt_vec[i]),
      .eq_o       (eq_vec[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (accept && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (run_end) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    priority if (run_end) begin
      overflow_seen_nxt = 1'b0;
    end else if (accept && !dup && full) begin
      overflow_seen_nxt = 1'b1;
    end else begin
      overflow_seen_nxt = overflow_seen_r;
    end
  end

  always_comb begin
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key_r      <= key_vec[0];
      out_last_r     <= !valid_vec[1];
      out_overflow_r <= overflow_seen_r;
    end
    if (!rst_n) begin
      state_r         <= ST_COLLECT;
      overflow_seen_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      overflow_seen_r <= overflow_seen_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key      = out_key_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_overflow_r;

  `include "assert_macros.svh"

  `ASSERT_PROP(a_valid_prefix, $onehot({1'b0, valid_vec} + 1'b1), "occupied cells not a prefix")
  `ASSERT_PROP(a_last_starts_drain, (accept && in_last) |=> (state_r == ST_DRAIN), "no drain")
  `ASSERT_PROP(a_run_end_empty, run_end |=> (valid_vec == '0), "chain not empty after run")
  `ASSERT_NEVER(a_overflow_full, (state_r == ST_COLLECT) && overflow_seen_r && !full, "overflow")

endmodule
`default_nettype wire
